>>> sv/rht_pkg.sv
// Shared types and constants for the rolling hash trigger window block.
package rht_pkg;

   localparam int MAX_WINDOW_DEF = 64;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int WSIZE_W = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int RSP_W = 40;
   localparam int RSP_PAD_W = RSP_W - HASH_W - 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HASH_PRIME = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIGGER_MOD = 2'd2;

   localparam logic [WSIZE_W-1:0] RESET_WINDOW = 7'd10;
   localparam logic [HASH_W-1:0] RESET_PRIME = 32'd1999999913;
   localparam logic [HASH_W-1:0] RESET_TRIGGER = 32'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_WEIGHT,
      ST_MUL,
      ST_RED,
      ST_ADD,
      ST_SHIFT,
      ST_DIV,
      ST_OUT
   } state_type;

   // Operands of one modular add step: (x + y + cin) mod m.
   typedef struct packed {
      logic [HASH_W-1:0] x;
      logic [HASH_W-1:0] y;
      logic cin;
      logic [HASH_W-1:0] m;
   } mod_req_type;

endpackage

>>> sv/rht_modunit.sv
// Shared modular add-and-reduce unit: one add and one compare-subtract.
module rht_modunit import rht_pkg::*; (
   input  mod_req_type       req,
   output logic [HASH_W-1:0] res
);

   logic [HASH_W+1:0] sum;
   logic [HASH_W+1:0] diff;

   // Callers keep x below m and y at most m, so a single subtract is enough.
   assign sum = {2'b00, req.x} + {2'b00, req.y} + {{(HASH_W+1){1'b0}}, req.cin};
   assign diff = sum - {2'b00, req.m};
   assign res = (sum >= {2'b00, req.m}) ? diff[HASH_W-1:0] : sum[HASH_W-1:0];

endmodule

>>> sv/rht_ring.sv
// Byte ring memory with a fill mark so that unwritten entries read as zero.
module rht_ring import rht_pkg::*; #(
   parameter int DEPTH = MAX_WINDOW_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   localparam int HW = $clog2(DEPTH + 1);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_ok_ff;
   logic [HW-1:0]     hi_ff;
   logic [HW-1:0]     hi_in;

   // Writes after a clear start at entry zero and only ever step forward by
   // one or return to zero, so the written entries always form a prefix.
   always_comb begin
      hi_in = hi_ff;
      if (clr) begin
         hi_in = '0;
      end else if (wr_en && (HW'(wr_addr) == hi_ff)) begin
         hi_in = hi_ff + HW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
      end else begin
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_ok_ff <= (HW'(rd_addr) < hi_ff);
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

>>> sv/rolling_hash_trigger_window_top.sv
// Top level of the sliding-window rolling hash with divisibility trigger.
//
//  Channel | Direction | Beat contents (lowest bits first)
//  req     | in        | tdata: byte_value; tuser: mode
//  rsp     | out       | tdata: hash_value, window_full, hash_divisible, trigger
//  csr     | in        | register index and 32-bit write data, no read-back
//
// An add beat moves from acceptance to a result in the output register
// through bit-serial passes in the one modular add unit. After a write to
// window_size or hash_prime, the next beat first rebuilds the weight of the
// oldest byte. A clear beat empties the window and rebuilds that weight.
// Reset is synchronous; the block takes a new beat while a result waits,
// but holds the next result until that one is taken.
module rolling_hash_trigger_window_top import rht_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,  // [7:0] byte_value
   input  logic                  req_tuser,  // [0] mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] hash_value, [32] window_full, [33] hash_divisible, [34] trigger
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [HASH_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int EW = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W = ($clog2(MAX_WINDOW * 8) > 5) ? $clog2(MAX_WINDOW * 8) : 5;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HASH_W-1:0]  acc_ff, acc_in;
   logic [HASH_W-1:0]  aux_ff, aux_in;
   logic [HASH_W-1:0]  negw_ff, negw_in;
   logic               weight_ready_ff, weight_ready_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [EW-1:0]      fill_ff, fill_in;
   logic [HASH_W-1:0]  running_ff, running_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               mode_ff, mode_in;
   logic               full_ff, full_in;
   logic               div_ff, div_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [WSIZE_W-1:0] window_size_ff, window_size_in;
   logic [HASH_W-1:0]  prime_ff, prime_in;
   logic [HASH_W-1:0]  trig_ff, trig_in;

   mod_req_type        unit_req;
   logic [HASH_W-1:0]  unit_res;
   logic               ring_wr_en;
   logic               ring_clr;
   logic [BYTE_W-1:0]  old_byte;

   logic [HASH_W-1:0]  ws_wide;
   logic [EW-1:0]      w_eff;
   logic [EW-1:0]      w_less_one;
   logic [EW-1:0]      wp_inc;
   logic [AW-1:0]      wp_next;
   logic [EW:0]        fill_inc;
   logic [EW-1:0]      fill_sat;

   rht_modunit u_modunit (
      .req (unit_req),
      .res (unit_res)
   );

   rht_ring #(
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .clr     (ring_clr),
      .wr_en   (ring_wr_en),
      .wr_addr (wp_ff),
      .wr_data (byte_ff),
      .rd_addr (wp_ff),
      .rd_data (old_byte)
   );

   // Effective window: saturated to the ring depth, and never below one.
   assign ws_wide = HASH_W'(window_size_ff);
   always_comb begin
      if (ws_wide > HASH_W'(MAX_WINDOW)) begin
         w_eff = EW'(MAX_WINDOW);
      end else if (ws_wide == '0) begin
         w_eff = EW'(1);
      end else begin
         w_eff = EW'(ws_wide);
      end
   end

   assign w_less_one = w_eff - EW'(1);
   assign wp_inc = EW'(wp_ff) + EW'(1);
   assign wp_next = (wp_inc >= w_eff) ? '0 : wp_inc[AW-1:0];
   assign fill_inc = {1'b0, fill_ff} + {{EW{1'b0}}, 1'b1};
   assign fill_sat = (fill_inc > {1'b0, w_eff}) ? w_eff : fill_inc[EW-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      aux_in = aux_ff;
      negw_in = negw_ff;
      weight_ready_in = weight_ready_ff;
      wp_in = wp_ff;
      fill_in = fill_ff;
      running_in = running_ff;
      byte_in = byte_ff;
      mode_in = mode_ff;
      full_in = full_ff;
      div_in = div_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      window_size_in = window_size_ff;
      prime_in = prime_ff;
      trig_in = trig_ff;
      unit_req = '{x: acc_ff, y: acc_ff, cin: 1'b0, m: prime_ff};
      ring_wr_en = 1'b0;
      ring_clr = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               mode_in = req_tuser;
               if (EW'(wp_ff) >= w_eff) begin
                  wp_in = '0;
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (mode_ff || !weight_ready_ff) begin
               acc_in = (prime_ff == HASH_W'(1)) ? '0 : HASH_W'(1);
               cnt_in = CNT_W'({w_less_one, 3'b000});
               state_in = ST_WEIGHT;
            end else begin
               acc_in = '0;
               cnt_in = CNT_W'(15);
               state_in = ST_MUL;
            end
            if (mode_ff) begin
               running_in = '0;
               wp_in = '0;
               fill_in = '0;
               full_in = 1'b0;
               div_in = 1'b0;
               ring_clr = 1'b1;
            end
         end
         ST_WEIGHT: begin
            // 256^(w-1) mod prime by repeated doubling.
            if (cnt_ff == '0) begin
               negw_in = prime_ff - acc_ff;
               weight_ready_in = 1'b1;
               if (mode_ff) begin
                  state_in = ST_OUT;
               end else begin
                  acc_in = '0;
                  cnt_in = CNT_W'(15);
                  state_in = ST_MUL;
               end
            end else begin
               acc_in = unit_res;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_MUL: begin
            // Minus the leaving byte's share: odd counts double, even counts
            // add the negated weight when that byte bit is set.
            if (!cnt_ff[0]) begin
               unit_req.y = old_byte[cnt_ff[3:1]] ? negw_ff : '0;
            end
            acc_in = unit_res;
            if (cnt_ff == '0) begin
               aux_in = unit_res;
               acc_in = '0;
               cnt_in = CNT_W'(31);
               state_in = ST_RED;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_RED: begin
            // The stored hash may exceed a newly written prime, so reduce it.
            unit_req.cin = running_ff[cnt_ff[4:0]];
            acc_in = unit_res;
            if (cnt_ff == '0) begin
               state_in = ST_ADD;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_ADD: begin
            unit_req.y = aux_ff;
            acc_in = unit_res;
            cnt_in = CNT_W'(7);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // Times 256 plus the new byte, one bit per cycle.
            unit_req.cin = byte_ff[cnt_ff[2:0]];
            if (cnt_ff == '0) begin
               running_in = (prime_ff == '0) ? '0 : unit_res;
               ring_wr_en = 1'b1;
               wp_in = wp_next;
               fill_in = fill_sat;
               full_in = (fill_sat == w_eff);
               acc_in = '0;
               cnt_in = CNT_W'(31);
               state_in = ST_DIV;
            end else begin
               acc_in = unit_res;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_DIV: begin
            unit_req.m = trig_ff;
            unit_req.cin = running_ff[cnt_ff[4:0]];
            acc_in = unit_res;
            if (cnt_ff == '0) begin
               div_in = (trig_ff == '0) ? (running_ff == '0) : (unit_res == '0);
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {{RSP_PAD_W{1'b0}}, full_ff & div_ff, div_ff, full_ff, running_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_addr)
            CSR_WINDOW_SIZE: begin
               window_size_in = csr_wdata[WSIZE_W-1:0];
               weight_ready_in = 1'b0;
            end
            CSR_HASH_PRIME: begin
               prime_in = csr_wdata;
               weight_ready_in = 1'b0;
            end
            CSR_TRIGGER_MOD: begin
               trig_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         weight_ready_ff <= 1'b0;
         wp_ff <= '0;
         fill_ff <= '0;
         running_ff <= '0;
         rsp_valid_ff <= 1'b0;
         window_size_ff <= RESET_WINDOW;
         prime_ff <= RESET_PRIME;
         trig_ff <= RESET_TRIGGER;
      end else begin
         state_ff <= state_in;
         weight_ready_ff <= weight_ready_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         running_ff <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         window_size_ff <= window_size_in;
         prime_ff <= prime_in;
         trig_ff <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      negw_ff <= negw_in;
      byte_ff <= byte_in;
      mode_ff <= mode_in;
      full_ff <= full_in;
      div_ff <= div_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
